[src/magnitude_db_colormap_macros.svh]
// Assertion helpers for the colormap block.
`ifndef MAGNITUDE_DB_COLORMAP_MACROS_SVH
`define MAGNITUDE_DB_COLORMAP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MDB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MDB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mdb_cmap_pkg.sv]
package mdb_cmap_pkg;

  // Word widths
  localparam int MAG_W     = 32;
  localparam int CH_W      = 8;
  localparam int FRAC_BITS = 16;
  localparam int LEAD_W    = $clog2(MAG_W);

  // log2: signed integer part and 16 fraction bits
  localparam int LOG_STEPS = 16;
  localparam int L2_INT_W  = 6;
  localparam int L2_W      = L2_INT_W + LOG_STEPS;

  // Decibel scaling, dB in Q.32
  localparam int NUM_W             = 42;
  localparam int DB_PER_OCTAVE_Q16 = 394566;
  localparam int DB_K_W            = 21;
  localparam int DB_OFFSET         = 60;
  localparam int DB_SPAN           = 55;

  // Normalized level n, Q0.16
  localparam int N_W           = 16;
  localparam int M_W           = NUM_W - 1 - N_W;
  localparam int MQ_W          = 22;
  localparam int SAT_M         = DB_SPAN * (2 ** N_W);
  localparam int RECIP_SHIFT   = 28;
  localparam int RECIP_DB_SPAN = (2 ** RECIP_SHIFT + DB_SPAN - 1) / DB_SPAN;
  localparam int MP_W          = 45;

  // Square root: two digits per stage
  localparam int G_W              = N_W;
  localparam int REM_W            = G_W + 1;
  localparam int SQRT_STEPS_STAGE = 2;
  localparam int SQRT_STAGES      = G_W / SQRT_STEPS_STAGE;

  // Colour segments
  localparam int G5_W      = G_W + 3;
  localparam int G10_W     = G_W + 4;
  localparam int T_W       = 18;
  localparam int COEF_W    = 8;
  localparam int PROD_W    = T_W + COEF_W;
  localparam int COL_SHIFT = 16;
  localparam int Y_W       = PROD_W - COL_SHIFT;
  localparam int LIM_NAVY   = 65536;   // 5g, 0.2
  localparam int LIM_CYAN   = 131072;  // 5g, 0.4
  localparam int LIM_GREEN  = 196608;  // 5g, 0.6
  localparam int LIM_YELLOW = 458752;  // 10g, 0.7
  localparam int BASE_YEL   = 393216;  // 10g, 0.6
  localparam int TOP_RED    = 655360;  // 10g, 1.0
  localparam int COEF_NAVY  = 191;
  localparam int COEF_RAMP  = 255;
  localparam int BLUE_BASE  = 64;
  localparam int DIV3_RECIP = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_W     = 2 * Y_W;

  typedef enum logic [2:0] {
    SEG_NAVY,
    SEG_CYAN,
    SEG_GREEN,
    SEG_YELLOW,
    SEG_RED
  } seg_e;

  typedef struct packed {
    logic [MAG_W-1:0]     x;
    logic [LOG_STEPS-1:0] frac;
    logic [LEAD_W-1:0]    lead;
    logic                 zero;
  } log_t;

  typedef struct packed {
    logic [G_W-1:0]   root;
    logic [REM_W-1:0] rem;
    logic [N_W-1:0]   dig;
  } sq_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

[src/mdb_cmap_if.sv]
interface mdb_cmap_in_if import mdb_cmap_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink (input valid, input magnitude, output ready);
endinterface

interface mdb_cmap_out_if import mdb_cmap_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[src/magnitude_db_colormap.sv]
// Spectrogram colour mapper: one unsigned Q16.16 magnitude word in, one RGB word out.
// in_i  : valid/ready channel carrying magnitude; a word is taken when both are high.
// out_o : valid/ready channel carrying red, green, blue; one result per input word,
//         in input order.
// Pipeline: a word taken on in_i reaches out_o through the 16 squaring stages of the
//   log2, the 8 square-root stages and the normalize, scale and colour stages around
//   them, ending in the output register.
// Throughput: one word per clock, sustained while the skid buffer is empty; each stage
//   holds one 32x32 multiply or two root digits at most.
// Reset (rst_ni low, async): all valid bits clear, pipeline and output are empty,
//   in_i.ready is high once reset is released. There is no other state.
// Receiver stall: the output register holds its word and a one-word skid buffer
//   catches the next finished result; only when the skid is occupied does the
//   whole pipeline freeze and in_i.ready drop. Nothing is lost or repeated.
// Zero magnitude skips the log and maps to (0,0,64); very loud input saturates the
// level at full scale.
`include "magnitude_db_colormap_macros.svh"

module magnitude_db_colormap import mdb_cmap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  mdb_cmap_in_if.sink      in_i,
  mdb_cmap_out_if.source   out_o
);

  // Stage order: A, norm, 16 log, C1, C2, root init, 8 root, E1, E2
  localparam int NSTG = 2 + LOG_STEPS + 2 + (SQRT_STAGES + 1) + 2;
  localparam logic signed [DB_K_W-1:0] DB_K = DB_K_W'(DB_PER_OCTAVE_Q16);
  localparam logic signed [NUM_W-1:0] DB_OFFSET_Q32 = NUM_W'(DB_OFFSET) <<< 32;

  // One squaring step of the fractional log2: x stays in [1,2) as Q1.31.
  function automatic log_t log_step(log_t s);
    logic [2*MAG_W-1:0] sq;
    log_t               o;
    sq = (2*MAG_W)'(s.x) * (2*MAG_W)'(s.x);
    o  = s;
    if (sq[2*MAG_W-1]) begin
      o.x    = sq[2*MAG_W-1 -: MAG_W];
      o.frac = {s.frac[LOG_STEPS-2:0], 1'b1};
    end else begin
      o.x    = sq[2*MAG_W-2 -: MAG_W];
      o.frac = {s.frac[LOG_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  // One restoring square-root digit.
  function automatic sq_t sqrt_step(sq_t s);
    logic [REM_W+1:0] r4;
    logic [REM_W+1:0] trial;
    sq_t              o;
    r4    = {s.rem, s.dig[N_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.dig = {s.dig[N_W-3:0], 2'b00};
    if (r4 >= trial) begin
      o.rem  = REM_W'(r4 - trial);
      o.root = {s.root[G_W-2:0], 1'b1};
    end else begin
      o.rem  = r4[REM_W-1:0];
      o.root = {s.root[G_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [LEAD_W-1:0] lead_one(logic [MAG_W-1:0] m);
    logic [LEAD_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) p = LEAD_W'(i);
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Global advance: the pipeline moves unless the skid word is waiting.
  // ---------------------------------------------------------------------------
  logic            pipe_en;
  logic [NSTG-1:0] v_q;
  logic            ov_q, ov_d;
  logic            sv_q, sv_d;

  assign pipe_en    = ~sv_q;
  assign in_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_en) begin
      v_q <= {v_q[NSTG-2:0], in_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: capture magnitude, find the leading one.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]  a_mag_q;
  logic [LEAD_W-1:0] a_lead_q, a_lead_d;
  logic              a_zero_q, a_zero_d;

  assign a_lead_d = lead_one(in_i.magnitude);
  assign a_zero_d = (in_i.magnitude == '0);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_mag_q  <= in_i.magnitude;
      a_lead_q <= a_lead_d;
      a_zero_q <= a_zero_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Normalize to Q1.31, then 16 squaring stages for the log2 fraction.
  // ---------------------------------------------------------------------------
  log_t lg_d [LOG_STEPS+1];
  log_t lg_q [LOG_STEPS+1];

  always_comb begin
    lg_d[0].x    = a_mag_q << (LEAD_W'(MAG_W - 1) - a_lead_q);
    lg_d[0].frac = '0;
    lg_d[0].lead = a_lead_q;
    lg_d[0].zero = a_zero_q;
  end

  for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_log
    assign lg_d[i] = log_step(lg_q[i-1]);
  end

  for (genvar i = 0; i <= LOG_STEPS; i++) begin : g_log_q
    always_ff @(posedge clk_i) begin
      if (pipe_en) lg_q[i] <= lg_d[i];
    end
  end

  // ---------------------------------------------------------------------------
  // C1: log2 in Q.16 times 20*log10(2) -> dB in Q.32.
  // ---------------------------------------------------------------------------
  logic signed [L2_INT_W-1:0] l2_int;
  logic signed [L2_W-1:0]     l2;
  logic signed [NUM_W-1:0]    c1_prod_d, c1_prod_q;
  logic                       c1_zero_q;

  always_comb begin
    l2_int    = L2_INT_W'({1'b0, lg_q[LOG_STEPS].lead}) - L2_INT_W'(FRAC_BITS);
    l2        = {l2_int, lg_q[LOG_STEPS].frac};
    c1_prod_d = NUM_W'(l2) * NUM_W'(DB_K);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      c1_prod_q <= c1_prod_d;
      c1_zero_q <= lg_q[LOG_STEPS].zero;
    end
  end

  // ---------------------------------------------------------------------------
  // C2: add the 60 dB floor, clamp below, flag saturation above.
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num;
  logic [M_W-1:0]          m_full;
  logic                    c2_zero_d, c2_zero_q;
  logic                    c2_sat_d, c2_sat_q;
  logic [MQ_W-1:0]         c2_m_q;

  always_comb begin
    num       = c1_prod_q + DB_OFFSET_Q32;
    m_full    = num[NUM_W-2 -: M_W];
    c2_zero_d = c1_zero_q | num[NUM_W-1] | (num == '0);
    c2_sat_d  = (m_full >= M_W'(SAT_M));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      c2_zero_q <= c2_zero_d;
      c2_sat_q  <= c2_sat_d;
      c2_m_q    <= m_full[MQ_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // C3: divide by the 55 dB span (reciprocal multiply, exact below 2^22),
  // giving level n; loaded straight into the first root stage.
  // ---------------------------------------------------------------------------
  logic [MP_W-1:0] q_prod;
  logic [N_W-1:0]  n_d;
  sq_t             sq_d [SQRT_STAGES+1];
  sq_t             sq_q [SQRT_STAGES+1];

  always_comb begin
    q_prod = MP_W'(c2_m_q) * MP_W'(RECIP_DB_SPAN);
    if (c2_zero_q) begin
      n_d = '0;
    end else if (c2_sat_q) begin
      n_d = '1;
    end else begin
      n_d = q_prod[RECIP_SHIFT +: N_W];
    end
    sq_d[0].root = '0;
    sq_d[0].rem  = '0;
    sq_d[0].dig  = n_d;
  end

  // Square root of n * 2^16: digits come from n, then zeros shift in.
  for (genvar i = 1; i <= SQRT_STAGES; i++) begin : g_sqrt
    always_comb begin
      sq_d[i] = sq_q[i-1];
      for (int k = 0; k < SQRT_STEPS_STAGE; k++) begin
        sq_d[i] = sqrt_step(sq_d[i]);
      end
    end
  end

  for (genvar i = 0; i <= SQRT_STAGES; i++) begin : g_sqrt_q
    always_ff @(posedge clk_i) begin
      if (pipe_en) sq_q[i] <= sq_d[i];
    end
  end

  // ---------------------------------------------------------------------------
  // E1: pick the colour segment and its ramp operand.
  // ---------------------------------------------------------------------------
  logic [G_W-1:0]   g;
  logic [G5_W-1:0]  g5;
  logic [G10_W-1:0] g10;
  seg_e             e1_seg_d, e1_seg_q;
  logic [T_W-1:0]   e1_t_d, e1_t_q;

  always_comb begin
    g   = sq_q[SQRT_STAGES].root;
    g5  = G5_W'(g) + (G5_W'(g) << 2);
    g10 = {g5, 1'b0};
    if (g5 < G5_W'(LIM_NAVY)) begin
      e1_seg_d = SEG_NAVY;
      e1_t_d   = T_W'(g5);
    end else if (g5 < G5_W'(LIM_CYAN)) begin
      e1_seg_d = SEG_CYAN;
      e1_t_d   = T_W'(g5 - G5_W'(LIM_NAVY));
    end else if (g5 < G5_W'(LIM_GREEN)) begin
      e1_seg_d = SEG_GREEN;
      e1_t_d   = T_W'(G5_W'(LIM_GREEN) - g5);
    end else if (g10 < G10_W'(LIM_YELLOW)) begin
      e1_seg_d = SEG_YELLOW;
      e1_t_d   = T_W'(g10 - G10_W'(BASE_YEL));
    end else begin
      e1_seg_d = SEG_RED;
      e1_t_d   = T_W'(G10_W'(TOP_RED) - g10);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e1_seg_q <= e1_seg_d;
      e1_t_q   <= e1_t_d;
    end
  end

  // ---------------------------------------------------------------------------
  // E2: scale the ramp by 191 (dark segment) or 255.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] e2_prod_d, e2_prod_q;
  seg_e              e2_seg_q;

  always_comb begin
    if (e1_seg_q == SEG_NAVY) begin
      e2_prod_d = PROD_W'(e1_t_q) * PROD_W'(COEF_NAVY);
    end else begin
      e2_prod_d = PROD_W'(e1_t_q) * PROD_W'(COEF_RAMP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e2_prod_q <= e2_prod_d;
      e2_seg_q  <= e1_seg_q;
    end
  end

  // Truncate to bytes; the top segment also divides by 3 (reciprocal, exact here).
  logic [Y_W-1:0]    y;
  logic [DIV3_W-1:0] div3_prod;
  rgb_t              rgb_new;

  always_comb begin
    y         = e2_prod_q[COL_SHIFT +: Y_W];
    div3_prod = DIV3_W'(y) * DIV3_W'(DIV3_RECIP);
    rgb_new   = '0;
    case (e2_seg_q)
      SEG_NAVY: begin
        rgb_new.blue = CH_W'(y) + CH_W'(BLUE_BASE);
      end
      SEG_CYAN: begin
        rgb_new.green = CH_W'(y);
        rgb_new.blue  = '1;
      end
      SEG_GREEN: begin
        rgb_new.green = '1;
        rgb_new.blue  = CH_W'(y);
      end
      SEG_YELLOW: begin
        rgb_new.red   = CH_W'(y);
        rgb_new.green = '1;
      end
      SEG_RED: begin
        rgb_new.red   = '1;
        rgb_new.green = div3_prod[DIV3_SHIFT +: CH_W];
      end
      default: begin
        rgb_new = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register plus one-word skid.
  // ---------------------------------------------------------------------------
  rgb_t out_q, skid_q;
  logic push;
  logic out_from_skid, out_from_new, ld_skid;

  assign push = pipe_en & v_q[NSTG-1];

  always_comb begin
    ov_d          = ov_q;
    sv_d          = sv_q;
    out_from_skid = 1'b0;
    out_from_new  = 1'b0;
    ld_skid       = 1'b0;
    if (sv_q) begin
      if (out_o.ready) begin
        out_from_skid = 1'b1;
        sv_d          = 1'b0;
      end
    end else if (push) begin
      if (!ov_q || out_o.ready) begin
        out_from_new = 1'b1;
        ov_d         = 1'b1;
      end else begin
        ld_skid = 1'b1;
        sv_d    = 1'b1;
      end
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_q <= skid_q;
    end else if (out_from_new) begin
      out_q <= rgb_new;
    end
    if (ld_skid) skid_q <= rgb_new;
  end

  assign out_o.valid = ov_q;
  assign out_o.red   = out_q.red;
  assign out_o.green = out_q.green;
  assign out_o.blue  = out_q.blue;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MDB_ASSERT_NEXT(a_valid_shift, clk_i, rst_ni, pipe_en,
                   v_q[NSTG-1:1] == $past(v_q[NSTG-2:0]), "valid bits lost in pipeline")
  `MDB_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, sv_q, ov_q,
                  "skid word held with empty output register")
  `MDB_ASSERT_NOW(a_red_no_blue, clk_i, rst_ni, ov_q && (out_o.red != '0),
                  out_o.blue == '0, "red and blue both lit")
  `MDB_ASSERT_NOW(a_dark_floor, clk_i, rst_ni,
                  ov_q && (out_o.red == '0) && (out_o.green == '0),
                  out_o.blue >= CH_W'(BLUE_BASE), "blue below dark floor")

endmodule

[verif/magnitude_db_colormap_test.sv]
`timescale 1ns / 1ps

module magnitude_db_colormap_test import mdb_cmap_pkg::*;;

  localparam int RANDOM_WORDS = 1250;
  localparam int CALM_TAIL    = 150;   // last words sent with no idling on either side
  localparam int DRAIN_CYCLES = 64;    // idle margin after the last expected word, so a stray output is still caught
  localparam int LEVEL_DIV    = DB_SPAN * 65536;

  logic clk_i;
  logic rst_ni;

  mdb_cmap_in_if  in_if ();
  mdb_cmap_out_if out_if ();

  magnitude_db_colormap dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  logic [MAG_W-1:0] pending_mags [$];   // magnitudes not yet offered
  rgb_t             expected_colors [$];
  int               total_words;
  int               accepted_count;
  int               mismatch_count;
  int               in_gap;
  int               out_gap;
  logic             word_taken;

  // Expected color for one magnitude.
  // log2 by repeated squaring (truncating), scale to dB in Q.32, offset by 60 dB,
  // divide by the 55 dB span into a Q0.16 level, floor sqrt, then five ramps.
  function automatic rgb_t map_magnitude(logic [MAG_W-1:0] mag);
    int                   lead;
    logic [63:0]          x;
    logic [LOG_STEPS-1:0] frac;
    longint               l2;
    longint               num;
    longint               level;
    longint               root;
    longint               trial;
    longint               g5;
    longint               g10;
    longint               r;
    longint               gr;
    longint               b;
    rgb_t                 c;
    level = 0;
    // zero magnitude never reaches the log; the level stays at 0
    if (mag != '0) begin
      lead = 0;
      for (int i = 0; i < MAG_W; i++) begin
        if (mag[i]) lead = i;
      end
      // normalize mantissa to [1,2) in Q1.31
      x = 64'(mag) << (31 - lead);
      frac = '0;
      for (int i = 0; i < LOG_STEPS; i++) begin
        x = (x * x) >> 31;
        frac = {frac[LOG_STEPS-2:0], 1'b0};
        if (x >= 64'h1_0000_0000) begin
          frac[0] = 1'b1;
          x = x >> 1;
        end
      end
      l2 = longint'(lead - FRAC_BITS) * 65536 + longint'(frac);
      num = l2 * DB_PER_OCTAVE_Q16 + (longint'(DB_OFFSET) <<< 32);
      if (num > 0) begin
        level = num / LEVEL_DIV;
        // loud input pins the level at full scale
        if (level > 65535) level = 65535;
      end
    end

    // square-root gamma: floor(sqrt(level * 2^16)), bit by bit
    root = 0;
    for (int i = G_W - 1; i >= 0; i--) begin
      trial = root | (longint'(1) <<< i);
      if (trial * trial <= (level <<< 16)) root = trial;
    end

    g5  = 5 * root;
    g10 = 10 * root;
    if (g5 < LIM_NAVY) begin
      r  = 0;
      gr = 0;
      b  = BLUE_BASE + ((COEF_NAVY * g5) >>> COL_SHIFT);
    end else if (g5 < LIM_CYAN) begin
      r  = 0;
      gr = (COEF_RAMP * (g5 - LIM_NAVY)) >>> COL_SHIFT;
      b  = 255;
    end else if (g5 < LIM_GREEN) begin
      r  = 0;
      gr = 255;
      b  = (COEF_RAMP * (LIM_GREEN - g5)) >>> COL_SHIFT;
    end else if (g10 < LIM_YELLOW) begin
      r  = (COEF_RAMP * (g10 - BASE_YEL)) >>> COL_SHIFT;
      gr = 255;
      b  = 0;
    end else begin
      // top ramp: 0.3 of full scale, so divide by 3 * 2^16
      r  = 255;
      gr = (COEF_RAMP * (TOP_RED - g10)) / (3 * 65536);
      b  = 0;
    end
    c.red   = r[CH_W-1:0];
    c.green = gr[CH_W-1:0];
    c.blue  = b[CH_W-1:0];
    return c;
  endfunction

  task automatic check_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Stimulus: drive on the falling edge, one assignment per signal per step.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || word_taken) begin
        if (in_gap > 0) begin
          in_if.valid <= 1'b0;
          in_gap--;
        end else if (pending_mags.size() > 0) begin
          in_if.valid     <= 1'b1;
          in_if.magnitude <= pending_mags.pop_front();
          if (pending_mags.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 4);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end

      // receiver stalls in random bursts
      if (out_gap > 0) begin
        out_if.ready <= 1'b0;
        out_gap--;
      end else begin
        out_if.ready <= 1'b1;
        if (pending_mags.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
          out_gap = $urandom_range(1, 4);
        end
      end
    end
  end

  // Monitor: sample both channels on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken <= in_if.valid && in_if.ready;
      // check first so a stray output cannot pair with a word taken this edge
      if (out_if.valid && out_if.ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected output word: red %0d green %0d blue %0d",
                 out_if.red, out_if.green, out_if.blue);
          mismatch_count++;
        end else begin
          rgb_t want;
          want = expected_colors.pop_front();
          check_channel("red", want.red, out_if.red);
          check_channel("green", want.green, out_if.green);
          check_channel("blue", want.blue, out_if.blue);
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_colors.push_back(map_magnitude(in_if.magnitude));
        accepted_count++;
      end
    end
  end

  initial begin
    logic [MAG_W-1:0] mag;
    int               pick;
    int               e;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.magnitude = '0;
    out_if.ready    = 1'b0;
    word_taken      = 1'b0;
    in_gap          = 0;
    out_gap         = 0;
    accepted_count  = 0;
    mismatch_count  = 0;

    // Corners: zero, the -60 dB floor (~65.5), the 0.2/0.4/0.6/0.7 gamma breaks
    // (~84, ~180, ~640, ~1460), saturation at -5 dB (~36854), full range and bit patterns.
    pending_mags = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'd64, 32'd65, 32'd66,
                     32'd84, 32'd85, 32'd180, 32'd181, 32'd640, 32'd641, 32'd1460,
                     32'd1461, 32'd36853, 32'd36854, 32'd36855, 32'h0000_FFFF,
                     32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                     32'hAAAA_AAAA};

    // Random: mostly log-uniform over the mapped dB range, rest spread over all bits.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        e   = $urandom_range(5, 16);
        mag = (32'd1 << e) | ($urandom & ((32'd1 << e) - 1));
      end else if (pick < 9) begin
        mag = $urandom >> $urandom_range(0, 31);
      end else begin
        mag = $urandom;
      end
      pending_mags.push_back(mag);
    end
    total_words = pending_mags.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_count == total_words);
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/mdb_cmap_pkg.sv
src/mdb_cmap_if.sv
src/magnitude_db_colormap.sv
verif/magnitude_db_colormap_test.sv
